>>> rtl/core/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the IPv4/IPv6 subnet calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

   localparam int unsigned ADDR_W = 128;
   localparam int unsigned HALF_W = 64;

   localparam logic [5:0] V4_MAX_PREFIX = 6'd32;
   localparam logic [5:0] V4_P2P_PREFIX = 6'd31;
   localparam logic [7:0] V6_MAX_PREFIX = 8'd128;
   localparam logic [7:0] V6_P2P_PREFIX = 8'd127;
   localparam logic [7:0] V6_HALF_PREFIX = 8'd64;

   localparam logic [31:0] PRIV_A_BASE = 32'h0A00_0000;
   localparam logic [31:0] PRIV_A_MASK = 32'hFF00_0000;
   localparam logic [31:0] PRIV_B_BASE = 32'hAC10_0000;
   localparam logic [31:0] PRIV_B_MASK = 32'hFFF0_0000;
   localparam logic [31:0] PRIV_C_BASE = 32'hC0A8_0000;
   localparam logic [31:0] PRIV_C_MASK = 32'hFFFF_0000;
   localparam logic [7:0]  ULA_FC      = 8'hFC;
   localparam logic [7:0]  ULA_FD      = 8'hFD;
   localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_FFFF;

   typedef struct packed {
      logic        is_ipv6;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  prefix_len;
   } isc_req_type;

   typedef struct packed {
      logic [63:0] mask_hi;
      logic [63:0] mask_lo;
      logic [63:0] net_hi;
      logic [63:0] net_lo;
      logic [63:0] bcast_hi;
      logic [63:0] bcast_lo;
      logic [63:0] first_hi;
      logic [63:0] first_lo;
      logic [63:0] last_hi;
      logic [63:0] last_lo;
      logic [63:0] host_count;
      logic        private_flag;
   } isc_rsp_type;

   function automatic logic v4_private(input logic [31:0] a);
      return ((a & PRIV_A_MASK) == PRIV_A_BASE) ||
             ((a & PRIV_B_MASK) == PRIV_B_BASE) ||
             ((a & PRIV_C_MASK) == PRIV_C_BASE);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/isc_req_if.sv
// ----------------------------------------------------------------------------
// isc_req_if
// Valid/ready channel carrying one address request.
// ----------------------------------------------------------------------------
`default_nettype none

interface isc_req_if;
   import isc_pkg::*;

   logic        valid;
   logic        ready;
   isc_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/isc_rsp_if.sv
// ----------------------------------------------------------------------------
// isc_rsp_if
// Valid/ready channel carrying one subnet result.
// ----------------------------------------------------------------------------
`default_nettype none

interface isc_rsp_if;
   import isc_pkg::*;

   logic        valid;
   logic        ready;
   isc_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ip_subnet_calculator_unit.sv
// ----------------------------------------------------------------------------
// ip_subnet_calculator_unit
// CIDR subnet calculator for IPv4 and IPv6: mask, network, broadcast,
// first/last host, host count and private-range flag.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_bus   in   valid/ready    isc_req_type  (family, address, prefix)
//  rsp_bus   out  valid/ready    isc_rsp_type  (subnet result)
//
//  Four register stages: mask, network/broadcast/count, low-half +/-1,
//  high-half carry. One transaction per cycle while rsp_bus is not stalled.
//  The last stage is the output register; each full stage holds while the one
//  after it is full and stalled, so bubbles are squeezed out on a stall.
//  Reset (synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_subnet_calculator_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   isc_req_if.sink    req_bus,
   isc_rsp_if.source  rsp_bus
);
   import isc_pkg::*;

   typedef struct packed {
      logic               is_v6;
      logic [ADDR_W-1:0]  addr;
      logic [ADDR_W-1:0]  mask;
      logic               p2p;      // prefix /31, /32, /127 or /128
      logic               single;   // full-length prefix
      logic               sat;      // IPv6 prefix below 64
      logic               priv;
   } s1_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  net;
      logic [ADDR_W-1:0]  bcast;
      logic               p2p;
      logic [HALF_W-1:0]  count;
      logic               priv;
   } s2_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  net;
      logic [ADDR_W-1:0]  bcast;
      logic [HALF_W-1:0]  first_lo;
      logic [HALF_W-1:0]  last_lo;
      logic               carry;
      logic               borrow;
      logic [HALF_W-1:0]  count;
      logic               priv;
   } s3_type;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        en1, en2, en3, en4;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   isc_rsp_type s4_ff, s4_in;

   // A stage advances when it is empty or its content moves on this cycle
   assign en4 = !v4_ff || rsp_bus.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;
   assign rsp_bus.valid = v4_ff;
   assign rsp_bus.data  = s4_ff;

   // Stage 1: clamp prefix, build mask, private-range check
   logic [5:0]  p4;
   logic [7:0]  p6;
   logic [31:0] mask4;
   logic [ADDR_W-1:0] mask6;
   logic        mapped;

   always_comb begin
      p4 = (req_bus.data.prefix_len > {2'b00, V4_MAX_PREFIX}) ?
           V4_MAX_PREFIX : req_bus.data.prefix_len[5:0];
      p6 = (req_bus.data.prefix_len > V6_MAX_PREFIX) ?
           V6_MAX_PREFIX : req_bus.data.prefix_len;
      mask4 = ~({32{1'b1}} >> p4);
      mask6 = ~({ADDR_W{1'b1}} >> p6);
      mapped = (req_bus.data.addr_hi == '0) &&
               (req_bus.data.addr_lo[63:32] == V4_MAPPED_TAG);

      s1_in.is_v6 = req_bus.data.is_ipv6;
      if (req_bus.data.is_ipv6) begin
         s1_in.addr   = {req_bus.data.addr_hi, req_bus.data.addr_lo};
         s1_in.mask   = mask6;
         s1_in.p2p    = (p6 >= V6_P2P_PREFIX);
         s1_in.single = (p6 == V6_MAX_PREFIX);
         s1_in.sat    = (p6 < V6_HALF_PREFIX);
         s1_in.priv   = mapped ? v4_private(req_bus.data.addr_lo[31:0]) :
                        ((req_bus.data.addr_hi[63:56] == ULA_FC) ||
                         (req_bus.data.addr_hi[63:56] == ULA_FD));
      end else begin
         s1_in.addr   = {96'd0, req_bus.data.addr_lo[31:0]};
         s1_in.mask   = {96'd0, mask4};
         s1_in.p2p    = (p4 >= V4_P2P_PREFIX);
         s1_in.single = (p4 == V4_MAX_PREFIX);
         s1_in.sat    = 1'b0;
         s1_in.priv   = v4_private(req_bus.data.addr_lo[31:0]);
      end
   end

   // Stage 2: network, broadcast, host count
   logic [HALF_W-1:0] host_bits;

   always_comb begin
      s2_in.mask = s1_ff.mask;
      s2_in.net  = s1_ff.addr & s1_ff.mask;
      if (s1_ff.is_v6) begin
         s2_in.bcast = s1_ff.addr | ~s1_ff.mask;
         host_bits   = ~s1_ff.mask[HALF_W-1:0];
      end else begin
         s2_in.bcast = {96'd0, s1_ff.addr[31:0] | ~s1_ff.mask[31:0]};
         host_bits   = {32'd0, ~s1_ff.mask[31:0]};
      end
      s2_in.p2p  = s1_ff.p2p;
      s2_in.priv = s1_ff.priv;
      if (s1_ff.p2p)
         s2_in.count = s1_ff.single ? 64'd1 : 64'd2;
      else if (s1_ff.sat)
         s2_in.count = {HALF_W{1'b1}};
      else
         s2_in.count = host_bits - 64'd1;
   end

   // Stage 3: low halves of first/last host, carry and borrow out
   always_comb begin
      s3_in.mask  = s2_ff.mask;
      s3_in.net   = s2_ff.net;
      s3_in.bcast = s2_ff.bcast;
      s3_in.count = s2_ff.count;
      s3_in.priv  = s2_ff.priv;
      if (s2_ff.p2p) begin
         s3_in.first_lo = s2_ff.net[HALF_W-1:0];
         s3_in.last_lo  = s2_ff.bcast[HALF_W-1:0];
         s3_in.carry    = 1'b0;
         s3_in.borrow   = 1'b0;
      end else begin
         s3_in.first_lo = s2_ff.net[HALF_W-1:0] + 64'd1;
         s3_in.last_lo  = s2_ff.bcast[HALF_W-1:0] - 64'd1;
         s3_in.carry    = &s2_ff.net[HALF_W-1:0];
         s3_in.borrow   = ~|s2_ff.bcast[HALF_W-1:0];
      end
   end

   // Stage 4: high halves, assemble the result
   always_comb begin
      s4_in.mask_hi      = s3_ff.mask[ADDR_W-1:HALF_W];
      s4_in.mask_lo      = s3_ff.mask[HALF_W-1:0];
      s4_in.net_hi       = s3_ff.net[ADDR_W-1:HALF_W];
      s4_in.net_lo       = s3_ff.net[HALF_W-1:0];
      s4_in.bcast_hi     = s3_ff.bcast[ADDR_W-1:HALF_W];
      s4_in.bcast_lo     = s3_ff.bcast[HALF_W-1:0];
      s4_in.first_hi     = s3_ff.net[ADDR_W-1:HALF_W] + {63'd0, s3_ff.carry};
      s4_in.first_lo     = s3_ff.first_lo;
      s4_in.last_hi      = s3_ff.bcast[ADDR_W-1:HALF_W] - {63'd0, s3_ff.borrow};
      s4_in.last_lo      = s3_ff.last_lo;
      s4_in.host_count   = s3_ff.count;
      s4_in.private_flag = s3_ff.priv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
   end

endmodule

`default_nettype wire

>>> bench/ip_subnet_calculator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_subnet_calculator_unit_tb
// Drives address/prefix transactions into the subnet calculator with bursty
// gaps on both channels and checks every result field against a fixed result
// or an in-bench 128-bit model of the CIDR math and the private-range rules.
// ----------------------------------------------------------------------------

module ip_subnet_calculator_unit_tb;
   import isc_pkg::*;

   localparam int RANDOM_ITEMS   = 1600;
   localparam int QUIET_TAIL     = 300;
   localparam int REPORT_LIMIT   = 10;
   localparam int STALL_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RESET_CYCLES   = 11;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      isc_req_type req;
      bit          fixed;
      isc_rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   bit   jitter_on;
   int   mismatch_count;
   int   stall_left;
   int   quiet_cycles;

   isc_rsp_type  pending_subnets [$];
   stim_row_type stim_rows [$];

   string field_names [12] = '{"mask_hi", "mask_lo", "net_hi", "net_lo", "bcast_hi",
      "bcast_lo", "first_hi", "first_lo", "last_hi", "last_lo", "host_count",
      "private_flag"};

   isc_req_if req_bus ();
   isc_rsp_if rsp_bus ();

   ip_subnet_calculator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic rfc1918(input logic [31:0] a);
      return (a[31:24] == 8'd10) || (a[31:20] == 12'hAC1) || (a[31:16] == 16'hC0A8);
   endfunction

   function automatic isc_rsp_type calc_subnet(input isc_req_type r);
      logic [127:0] addr, mask, net, bcast, first, last;
      logic [31:0]  a4, m4, n4, b4;
      int unsigned  plen;
      isc_rsp_type  s;
      s = '0;
      plen = r.prefix_len;
      if (!r.is_ipv6) begin
         if (plen > V4_MAX_PREFIX) plen = V4_MAX_PREFIX;
         a4 = r.addr_lo[31:0];
         m4 = ~({32{1'b1}} >> plen);
         n4 = a4 & m4;
         b4 = a4 | ~m4;
         s.mask_lo  = {32'd0, m4};
         s.net_lo   = {32'd0, n4};
         s.bcast_lo = {32'd0, b4};
         if (plen >= V4_P2P_PREFIX) begin
            s.first_lo   = {32'd0, n4};
            s.last_lo    = {32'd0, b4};
            s.host_count = (plen == V4_P2P_PREFIX) ? 64'd2 : 64'd1;
         end else begin
            s.first_lo   = {32'd0, 32'(n4 + 32'd1)};
            s.last_lo    = {32'd0, 32'(b4 - 32'd1)};
            s.host_count = (64'd1 << (32 - plen)) - 64'd2;
         end
         s.private_flag = rfc1918(a4);
      end else begin
         if (plen > V6_MAX_PREFIX) plen = V6_MAX_PREFIX;
         addr  = {r.addr_hi, r.addr_lo};
         mask  = ~({128{1'b1}} >> plen);
         net   = addr & mask;
         bcast = addr | ~mask;
         if (plen >= V6_P2P_PREFIX) begin
            first        = net;
            last         = bcast;
            s.host_count = (plen == V6_P2P_PREFIX) ? 64'd2 : 64'd1;
         end else begin
            first = net + 128'd1;
            last  = bcast - 128'd1;
            if (plen < V6_HALF_PREFIX)       s.host_count = ALL_ONES;
            else if (plen == V6_HALF_PREFIX) s.host_count = ALL_ONES - 64'd1;
            else                             s.host_count = (64'd1 << (128 - plen)) - 64'd2;
         end
         {s.mask_hi, s.mask_lo}   = mask;
         {s.net_hi, s.net_lo}     = net;
         {s.bcast_hi, s.bcast_lo} = bcast;
         {s.first_hi, s.first_lo} = first;
         {s.last_hi, s.last_lo}   = last;
         // IPv4-mapped addresses take the embedded address's private status
         if (r.addr_hi == 64'd0 && r.addr_lo[63:32] == V4_MAPPED_TAG)
            s.private_flag = rfc1918(r.addr_lo[31:0]);
         else
            s.private_flag = (r.addr_hi[63:56] == ULA_FC) || (r.addr_hi[63:56] == ULA_FD);
      end
      return s;
   endfunction

   function automatic void split_fields(input isc_rsp_type r, output logic [63:0] f [12]);
      f = '{r.mask_hi, r.mask_lo, r.net_hi, r.net_lo, r.bcast_hi, r.bcast_lo,
            r.first_hi, r.first_lo, r.last_hi, r.last_lo, r.host_count,
            {63'd0, r.private_flag}};
   endfunction

   function automatic void note_mismatch(input string what, input logic [63:0] want,
                                         input logic [63:0] got);
      if (mismatch_count < REPORT_LIMIT)
         $display("[%0t] mismatch %s: expected %h actual %h", $realtime, what, want, got);
      mismatch_count++;
   endfunction

   function automatic logic [31:0] near_private_v4();
      logic [31:0] a;
      a = $urandom;
      case ($urandom_range(0, 3))
         0: a[31:24] = 8'd10;
         1: a[31:20] = 12'hAC1;
         2: a[31:16] = 16'hC0A8;
         default: a[31:24] = $urandom_range(0, 1) ? 8'hAC : 8'hC0;
      endcase
      return a;
   endfunction

   function automatic isc_req_type random_request();
      isc_req_type r;
      logic [7:0]  edges4 [6] = '{8'd0, 8'd1, 8'd30, 8'd31, 8'd32, 8'd33};
      logic [7:0]  edges6 [9] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd126, 8'd127,
                                  8'd128, 8'd129};
      r.is_ipv6 = 1'($urandom_range(0, 1));
      r.addr_hi = {$urandom, $urandom};
      r.addr_lo = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1: r.addr_lo[31:0] = near_private_v4();
         2: begin
            r.addr_hi = 64'd0;
            r.addr_lo[63:32] = $urandom_range(0, 3) != 0 ? V4_MAPPED_TAG : 32'h0000_FFFE;
            if ($urandom_range(0, 1)) r.addr_lo[31:0] = near_private_v4();
         end
         3: r.addr_hi[63:56] = $urandom_range(0, 1) ? ULA_FC : ULA_FD;
         4: r.addr_hi[63:58] = 6'b111111;
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0: r.prefix_len = 8'($urandom_range(0, 255));
         1: r.prefix_len = r.is_ipv6 ? edges6[$urandom_range(0, 8)]
                                     : edges4[$urandom_range(0, 5)];
         default: r.prefix_len = r.is_ipv6 ? 8'($urandom_range(0, 128))
                                           : 8'($urandom_range(0, 32));
      endcase
      return r;
   endfunction

   task automatic add_row(input isc_req_type q, input bit fixed, input isc_rsp_type e);
      stim_row_type row;
      row.req   = q;
      row.fixed = fixed;
      row.rsp   = e;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   // Present one transaction, hold it until accepted, queue its expected result.
   task automatic push_request(input isc_req_type r, input bit fixed, input isc_rsp_type e);
      if (jitter_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= r;
      do @(posedge clock); while (!req_bus.ready);
      pending_subnets.insert(pending_subnets.size(), fixed ? e : calc_subnet(r));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_subnets.size() != 0);
   endtask

   // Result side: bursty back-pressure while jitter is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= (stall_left == 1);
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
         stall_left    <= $urandom_range(1, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      isc_rsp_type want;
      logic [63:0] want_f [12];
      logic [63:0] got_f [12];
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_subnets.size() == 0) begin
            note_mismatch("unexpected result", 64'd0, rsp_bus.data.net_lo);
         end else begin
            want = pending_subnets.pop_front();
            split_fields(want, want_f);
            split_fields(rsp_bus.data, got_f);
            for (int k = 0; k < 12; k++)
               if (want_f[k] !== got_f[k]) note_mismatch(field_names[k], want_f[k], got_f[k]);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.data   = '0;
      rsp_bus.ready  = 1'b0;
      jitter_on      = 1'b1;
      stall_left     = 0;
      quiet_cycles   = 0;
      mismatch_count = 0;

      // Rows with a fixed result are the ones that can be read off directly.
      add_row(isc_req_type'{1'b0, 64'd0, 64'd0, 8'd0}, 1'b1,
              isc_rsp_type'{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'hFFFF_FFFF,
                            64'd0, 64'd1, 64'd0, 64'hFFFF_FFFE, 64'hFFFF_FFFE, 1'b0});
      add_row(isc_req_type'{1'b0, ALL_ONES, ALL_ONES, 8'd32}, 1'b1,
              isc_rsp_type'{64'd0, 64'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF,
                            64'd0, 64'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF, 64'd1, 1'b0});
      add_row(isc_req_type'{1'b0, 64'd0, 64'h0A00_0001, 8'd255}, 1'b1,
              isc_rsp_type'{64'd0, 64'hFFFF_FFFF, 64'd0, 64'h0A00_0001, 64'd0, 64'h0A00_0001,
                            64'd0, 64'h0A00_0001, 64'd0, 64'h0A00_0001, 64'd1, 1'b1});
      add_row(isc_req_type'{1'b0, 64'd0, 64'hC0A8_0101, 8'd31}, 1'b1,
              isc_rsp_type'{64'd0, 64'hFFFF_FFFE, 64'd0, 64'hC0A8_0100, 64'd0, 64'hC0A8_0101,
                            64'd0, 64'hC0A8_0100, 64'd0, 64'hC0A8_0101, 64'd2, 1'b1});
      add_row(isc_req_type'{1'b1, 64'd0, 64'd0, 8'd0}, 1'b1,
              isc_rsp_type'{64'd0, 64'd0, 64'd0, 64'd0, ALL_ONES, ALL_ONES,
                            64'd0, 64'd1, ALL_ONES, ALL_ONES - 64'd1, ALL_ONES, 1'b0});
      add_row(isc_req_type'{1'b1, ALL_ONES, ALL_ONES, 8'd128}, 1'b1,
              isc_rsp_type'{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                            ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 64'd1, 1'b0});
      add_row(isc_req_type'{1'b1, 64'hFC00_0000_0000_0000, 64'd1, 8'd200}, 1'b1,
              isc_rsp_type'{ALL_ONES, ALL_ONES, 64'hFC00_0000_0000_0000, 64'd1,
                            64'hFC00_0000_0000_0000, 64'd1, 64'hFC00_0000_0000_0000, 64'd1,
                            64'hFC00_0000_0000_0000, 64'd1, 64'd1, 1'b1});
      add_row(isc_req_type'{1'b1, 64'd0, 64'h0000_FFFF_0A00_0001, 8'd127}, 1'b1,
              isc_rsp_type'{ALL_ONES, ALL_ONES - 64'd1, 64'd0, 64'h0000_FFFF_0A00_0000,
                            64'd0, 64'h0000_FFFF_0A00_0001, 64'd0, 64'h0000_FFFF_0A00_0000,
                            64'd0, 64'h0000_FFFF_0A00_0001, 64'd2, 1'b1});
      add_row(isc_req_type'{1'b0, 64'd0, 64'h0A01_0203, 8'd8}, 1'b0, '0);
      add_row(isc_req_type'{1'b0, 64'd0, 64'hAC10_0504, 8'd12}, 1'b0, '0);
      add_row(isc_req_type'{1'b0, 64'd0, 64'hAC1F_FFFF, 8'd20}, 1'b0, '0);
      add_row(isc_req_type'{1'b0, 64'd0, 64'hAC20_0000, 8'd16}, 1'b0, '0);
      add_row(isc_req_type'{1'b0, ALL_ONES, 64'h1234_5678_AC0F_0001, 8'd1}, 1'b0, '0);
      add_row(isc_req_type'{1'b0, 64'd0, 64'hC0A8_0101, 8'd24}, 1'b0, '0);
      add_row(isc_req_type'{1'b0, 64'd0, 64'hC0A9_0000, 8'd30}, 1'b0, '0);
      add_row(isc_req_type'{1'b0, 64'd0, 64'h0B00_0000, 8'd33}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'hFD12_3456_0000_0000, 64'd7, 8'd48}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'hFE00_0000_0000_0000, 64'd3, 8'd126}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'h2001_0DB8_0000_0001, ALL_ONES, 8'd65}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'h2001_0DB8_0000_0001, ALL_ONES, 8'd64}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'h2001_0DB8_0000_0001, ALL_ONES, 8'd63}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'h8000_0000_0000_0000, 64'd0, 8'd129}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'd0, 64'h0000_FFFF_0808_0808, 8'd96}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'd0, 64'h0000_FFFE_0A00_0001, 8'd96}, 1'b0, '0);
      add_row(isc_req_type'{1'b1, 64'd1, 64'h0000_FFFF_AC14_0001, 8'd100}, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) push_request(stim_rows[i].req, stim_rows[i].fixed, stim_rows[i].rsp);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            jitter_on <= (n < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         if (n == RANDOM_ITEMS / 2) wait_drained();
         push_request(random_request(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (pending_subnets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
